// File: hw/rtl/rvalu_pkg.sv
// Shared types, constants and decode helpers for the RV32IM integer ALU.
package rvalu_pkg;

  localparam int XLEN        = 32;
  localparam int QUEUE_DEPTH = 4;
  // Entry stage, 32 divide steps, one finishing stage.
  localparam int PIPE_STAGES = XLEN + 2;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_SLL    = 5'd2,
    OP_SLT    = 5'd3,
    OP_SLTU   = 5'd4,
    OP_XOR    = 5'd5,
    OP_SRL    = 5'd6,
    OP_SRA    = 5'd7,
    OP_OR     = 5'd8,
    OP_AND    = 5'd9,
    OP_MUL    = 5'd10,
    OP_MULH   = 5'd11,
    OP_MULHSU = 5'd12,
    OP_MULHU  = 5'd13,
    OP_DIV    = 5'd14,
    OP_DIVU   = 5'd15,
    OP_REM    = 5'd16,
    OP_REMU   = 5'd17,
    OP_NONE   = 5'd31
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [XLEN-1:0]  a;
    logic [XLEN-1:0]  b;
  } dec_t;

  // What the queue head shows to the execute side.
  typedef struct packed {
    logic valid;
    dec_t item;
  } head_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic             special;
    logic             neg_q;
    logic             neg_r;
    logic [XLEN-1:0]  res;
    logic [XLEN-1:0]  rem;
    logic [XLEN-1:0]  quo;
    logic [XLEN-1:0]  dvd;
    logic [XLEN-1:0]  dvs;
  } stage_t;

  function automatic op_t decode(input logic [4:0] cmd);
    op_t op;
    case (cmd)
      5'd0:    op = OP_ADD;
      5'd1:    op = OP_SUB;
      5'd2:    op = OP_SLL;
      5'd3:    op = OP_SLT;
      5'd4:    op = OP_SLTU;
      5'd5:    op = OP_XOR;
      5'd6:    op = OP_SRL;
      5'd7:    op = OP_SRA;
      5'd8:    op = OP_OR;
      5'd9:    op = OP_AND;
      5'd10:   op = OP_MUL;
      5'd11:   op = OP_MULH;
      5'd12:   op = OP_MULHSU;
      5'd13:   op = OP_MULHU;
      5'd14:   op = OP_DIV;
      5'd15:   op = OP_DIVU;
      5'd16:   op = OP_REM;
      5'd17:   op = OP_REMU;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic is_mul(input op_t op);
    return (op == OP_MUL) || (op == OP_MULH) || (op == OP_MULHSU) || (op == OP_MULHU);
  endfunction

  function automatic logic is_div(input op_t op);
    return (op == OP_DIV) || (op == OP_DIVU) || (op == OP_REM) || (op == OP_REMU);
  endfunction

endpackage

// File: hw/rtl/rvalu_front.sv
// Front end: accepts items, decodes the command and queues them for execution.
module rvalu_front
  import rvalu_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [4:0]       command,
  input  logic [XLEN-1:0]  operand_a,
  input  logic [XLEN-1:0]  operand_b,
  output head_t            head,
  input  logic             take
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  dec_t            q [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   cnt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt == CW'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = take && (cnt != '0);

  assign head.valid = (cnt != '0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= '{op: decode(command), a: operand_a, b: operand_b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      cnt <= cnt + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// File: hw/rtl/rvalu_back.sv
// Execute pipeline: ALU ops at entry, split multiplier, one-step-per-stage divider.
module rvalu_back
  import rvalu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  head_t            head,
  output logic             take,
  output logic             empty,
  input  logic             pop,
  output logic [XLEN-1:0]  result
);

  localparam int LAST = PIPE_STAGES - 1;

  stage_t           pipe [PIPE_STAGES];
  stage_t           nxt  [PIPE_STAGES];
  logic             advance;
  logic [1:0]       ocnt;
  logic [XLEN-1:0]  odata [2];
  logic             opush;
  logic             opop;

  // Entry stage: ALU ops finish here, multiplies form partial products,
  // divides take magnitudes and catch the special cases.
  function automatic stage_t prep(input dec_t d);
    stage_t s;
    logic [4:0] sh;
    logic sgn;
    logic na;
    logic nb;
    s = '0;
    sh = d.b[4:0];
    s.op = d.op;
    case (d.op)
      OP_ADD:  s.res = d.a + d.b;
      OP_SUB:  s.res = d.a - d.b;
      OP_SLL:  s.res = d.a << sh;
      OP_SLT:  s.res = {31'd0, $signed(d.a) < $signed(d.b)};
      OP_SLTU: s.res = {31'd0, d.a < d.b};
      OP_XOR:  s.res = d.a ^ d.b;
      OP_SRL:  s.res = d.a >> sh;
      OP_SRA:  s.res = $unsigned($signed(d.a) >>> sh);
      OP_OR:   s.res = d.a | d.b;
      OP_AND:  s.res = d.a & d.b;
      default: s.res = '0;
    endcase
    if (is_mul(d.op)) begin
      s.rem = d.a[15:0]  * d.b[15:0];
      s.quo = d.a[15:0]  * d.b[31:16];
      s.dvd = d.a[31:16] * d.b[15:0];
      s.dvs = d.a[31:16] * d.b[31:16];
      // Signed correction to subtract from the unsigned high word.
      s.res = (((d.op == OP_MULH) || (d.op == OP_MULHSU)) && d.a[31] ? d.b : '0) +
              ((d.op == OP_MULH) && d.b[31] ? d.a : '0);
    end
    if (is_div(d.op)) begin
      sgn = (d.op == OP_DIV) || (d.op == OP_REM);
      na  = sgn && d.a[31];
      nb  = sgn && d.b[31];
      s.dvd   = na ? (~d.a + 1'b1) : d.a;
      s.dvs   = nb ? (~d.b + 1'b1) : d.b;
      s.neg_q = na ^ nb;
      s.neg_r = na;
      if (d.b == '0) begin
        s.special = 1'b1;
        s.res = ((d.op == OP_REM) || (d.op == OP_REMU)) ? d.a : '1;
      end else if (sgn && (d.a == {1'b1, {(XLEN-1){1'b0}}}) && (d.b == '1)) begin
        s.special = 1'b1;
        s.res = (d.op == OP_REM) ? '0 : {1'b1, {(XLEN-1){1'b0}}};
      end
    end
    return s;
  endfunction

  function automatic stage_t step(input stage_t p, input int k);
    stage_t s;
    logic [2*XLEN-1:0] prod;
    logic [XLEN:0] t;
    s = p;
    prod = '0;
    t = '0;
    if (is_mul(p.op)) begin
      if (k == 1) begin
        prod = {p.dvs, {XLEN{1'b0}}} + {16'd0, p.quo, 16'd0} + {16'd0, p.dvd, 16'd0} +
               {{XLEN{1'b0}}, p.rem};
        s.rem = prod[XLEN-1:0];
        s.quo = prod[2*XLEN-1:XLEN];
      end else if (k == 2) begin
        s.res = (p.op == OP_MUL) ? p.rem : (p.quo - p.res);
      end
    end else if (is_div(p.op)) begin
      if (k <= XLEN) begin
        // Restoring step: bring down one dividend bit, subtract if it fits.
        t = {p.rem, p.dvd[XLEN-1]} - {1'b0, p.dvs};
        s.dvd = {p.dvd[XLEN-2:0], 1'b0};
        if (!t[XLEN]) begin
          s.rem = t[XLEN-1:0];
          s.quo = {p.quo[XLEN-2:0], 1'b1};
        end else begin
          s.rem = {p.rem[XLEN-2:0], p.dvd[XLEN-1]};
          s.quo = {p.quo[XLEN-2:0], 1'b0};
        end
      end else if (!p.special) begin
        if ((p.op == OP_REM) || (p.op == OP_REMU)) begin
          s.res = p.neg_r ? (~p.rem + 1'b1) : p.rem;
        end else begin
          s.res = p.neg_q ? (~p.quo + 1'b1) : p.quo;
        end
      end
    end
    return s;
  endfunction

  // The whole pipeline moves together whenever the output buffer has a slot.
  assign advance = (ocnt != 2'd2);
  assign take    = advance && head.valid;
  assign opush   = advance && pipe[LAST].valid;
  assign opop    = pop && (ocnt != 2'd0);
  assign empty   = (ocnt == 2'd0);
  assign result  = odata[0];

  always_comb begin
    nxt[0] = prep(head.item);
    nxt[0].valid = take;
    for (int k = 1; k < PIPE_STAGES; k++) begin
      nxt[k] = step(pipe[k-1], k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        pipe[k].valid <= 1'b0;
      end
    end else if (advance) begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (opop) begin
      odata[0] <= odata[1];
    end
    if (opush) begin
      if ((ocnt == 2'd0) || ((ocnt == 2'd1) && opop)) begin
        odata[0] <= pipe[LAST].res;
      end else begin
        odata[1] <= pipe[LAST].res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt + 2'(opush) - 2'(opop);
    end
  end

endmodule

// File: hw/rtl/rv32im_integer_alu.sv
// Top level of the RV32IM integer ALU: decode queue feeding the execute pipeline.
//
//   channel   direction  handshake         fields
//   input     in         push / full       command, operand_a, operand_b
//   result    out        empty / pop       result
//
// Every item, whatever its operation, passes the same 34-stage execute
// pipeline, so results leave in the order the items came in. The length is
// set by the divider, which resolves one quotient bit per stage.
// One item per cycle is sustained while results are taken. A full two-entry
// result buffer freezes the pipeline; the decode queue keeps accepting until
// it fills too. Reset empties the queue, the pipeline and the result buffer.
module rv32im_integer_alu
  import rvalu_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH  // decode queue entries, 2 or more
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [4:0]       command,
  input  logic [XLEN-1:0]  operand_a,
  input  logic [XLEN-1:0]  operand_b,
  output logic             empty,
  input  logic             pop,
  output logic [XLEN-1:0]  result
);

  head_t head;
  logic  take;

  // Front end decodes and buffers items, so a stalled pipeline does not
  // immediately push back on the producer.
  rvalu_front #(.QDEPTH(QDEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .head      (head),
    .take      (take)
  );

  // Back end executes items and holds finished results for the consumer.
  rvalu_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .take   (take),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// File: hw/rtl/rvalu_checker.sv
// Port-level checks for the RV32IM integer ALU and their binding.
module rvalu_checker
  import rvalu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             full,
  input  logic             empty,
  input  logic             pop,
  input  logic [XLEN-1:0]  result
);

  // Reset leaves no result and room for input.
  a_rst_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("block not empty after reset");

  // The pipeline is long; nothing can come out right after reset.
  a_rst_latency: assert property (@(posedge clk) rst ##1 !rst |=> empty)
    else $error("result appeared too soon after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("waiting result changed");

endmodule

bind rv32im_integer_alu rvalu_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
